// ===== sv/srag_pkg.sv =====
// Shared types and constants for the storage request address generator.
`timescale 1ns / 1ps
package srag_pkg;

  localparam int LBA_W   = 48;
  localparam int SPAN_W  = LBA_W + 1;
  localparam int CNT_W   = 16;
  localparam int DRAW_W  = 32;
  localparam int Q16_W   = 16;
  localparam int THR_W   = 17;
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 3;
  localparam int STEP_W  = 6;
  localparam int ADD_W   = SPAN_W + 1;

  localparam int MUL_STEPS = DRAW_W;
  localparam int REM_STEPS = LBA_W;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_ADDRESS_MODE   = 3'd0;
  localparam logic [IDX_W-1:0] REG_READ_THRESHOLD = 3'd1;
  localparam logic [IDX_W-1:0] REG_HOT_THRESHOLD  = 3'd2;
  localparam logic [IDX_W-1:0] REG_FIRST_LBA      = 3'd3;
  localparam logic [IDX_W-1:0] REG_LAST_LBA       = 3'd4;
  localparam logic [IDX_W-1:0] REG_HOT_END_LBA    = 3'd5;
  localparam logic [IDX_W-1:0] REG_FIXED_SIZE     = 3'd6;
  localparam logic [IDX_W-1:0] REG_ALIGN_SIZE     = 3'd7;

  // Address modes
  localparam logic [MODE_W-1:0] MODE_STREAM  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_HOTCOLD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] address_mode;
    logic [THR_W-1:0]  read_threshold;
    logic [THR_W-1:0]  hot_threshold;
    logic [LBA_W-1:0]  first_lba;
    logic [LBA_W-1:0]  last_lba;
    logic [LBA_W-1:0]  hot_end_lba;
    logic [CNT_W-1:0]  fixed_size;
    logic [CNT_W-1:0]  align_size;
  } cfg_t;

  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_REM = 1'b1
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== sv/storage_request_address_generator.sv =====
// Top level of the storage request address generator.
//
// Usage: each input word carries an opcode and four random draws. Opcode 0
// seeds the streaming pointer from the address draw (mapped onto the working
// set and aligned down) and gives no output word. Opcode 1 gives one request
// word: is_read, req_lba, sector_count.
// Input channel: in_valid / in_stall; in_stall is high while an item is in
// work, so one item is handled at a time. Output channel: out_valid /
// out_stall behind an output register; the next item is accepted while a
// finished request waits there, and a finished request waits in the last
// sequencer step while the register is still full.
// Configuration: cfg_valid / cfg_ready, always ready; write only while idle.
// Arithmetic: one shared unit does a 32-step multiply for each draw mapping and
// a 48-step remainder for each alignment.
// Reset: synchronous, active high; restores register defaults, clears the
// streaming pointer and empties the output register. No clearing pass.
`timescale 1ns / 1ps
module storage_request_address_generator (
  input  logic                        clk,
  input  logic                        rst,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic [srag_pkg::Q16_W-1:0]  type_draw,
  input  logic [srag_pkg::Q16_W-1:0]  hot_draw,
  input  logic [srag_pkg::DRAW_W-1:0] address_draw,
  input  logic signed [15:0]          size_draw,
  // request words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        is_read,
  output logic [srag_pkg::LBA_W-1:0]  req_lba,
  output logic [srag_pkg::CNT_W-1:0]  sector_count,
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srag_pkg::IDX_W-1:0]  cfg_index,
  input  logic [srag_pkg::LBA_W-1:0]  cfg_data
);
  import srag_pkg::*;

  localparam logic OPC_SEED = 1'b0;
  localparam logic OPC_GEN  = 1'b1;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_MUL    = 11'b000_0000_0010,
    ST_SUM    = 11'b000_0000_0100,
    ST_CHECK  = 11'b000_0000_1000,
    ST_STREAM = 11'b000_0001_0000,
    ST_PREM   = 11'b000_0010_0000,
    ST_PFIX   = 11'b000_0100_0000,
    ST_ALIGN  = 11'b000_1000_0000,
    ST_SREM   = 11'b001_0000_0000,
    ST_SFIX   = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  cfg_t        cfg;
  state_t      state;
  state_t      state_next;
  unit_ctrl_t  unit_ctrl;
  unit_stat_t  unit_stat;
  logic [SPAN_W-1:0] prod_hi;
  logic [CNT_W-1:0]  rem;

  // item registers
  logic              op;
  logic              read_q;
  logic [CNT_W-1:0]  count;
  logic [SPAN_W-1:0] map_lo;
  logic [SPAN_W-1:0] span;
  logic [LBA_W-1:0]  start;
  logic [LBA_W-1:0]  ptr;
  logic [LBA_W-1:0]  ptr_tmp;

  logic              accept;
  logic              align_on;
  logic              out_free;
  logic [CNT_W-1:0]  size_u;
  logic [CNT_W-1:0]  count_calc;
  logic              hot_sel;
  logic [SPAN_W-1:0] lo_calc;
  logic [SPAN_W-1:0] hi_calc;
  logic [SPAN_W-1:0] span_calc;
  logic [SPAN_W-1:0] mapped;
  logic [SPAN_W-1:0] ptr_sum;
  logic              wrap;
  logic [LBA_W-1:0]  stream_next;
  logic [LBA_W-1:0]  start_down;
  logic [SPAN_W-1:0] check_sum;

  srag_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign align_on = (cfg.align_size != '0);
  assign out_free = !out_valid || !out_stall;

  // Sector count: fixed size, else the size draw raised to at least one
  assign size_u = $unsigned(size_draw);
  always_comb begin
    if (cfg.fixed_size != '0) begin
      count_calc = cfg.fixed_size;
    end else if (size_u[CNT_W-1] || size_u == '0) begin
      count_calc = CNT_W'(1);
    end else begin
      count_calc = size_u;
    end
  end

  // Range for the draw mapping; an empty range maps to its low end (span 0)
  assign hot_sel = {1'b0, hot_draw} < cfg.hot_threshold;
  always_comb begin
    if (opcode == OPC_GEN && cfg.address_mode == MODE_HOTCOLD) begin
      if (hot_sel) begin
        lo_calc = {1'b0, cfg.hot_end_lba} + SPAN_W'(1);
        hi_calc = {1'b0, cfg.last_lba};
      end else begin
        lo_calc = {1'b0, cfg.first_lba};
        hi_calc = {1'b0, cfg.hot_end_lba};
      end
    end else begin
      lo_calc = {1'b0, cfg.first_lba};
      hi_calc = {1'b0, cfg.last_lba};
    end
    span_calc = (hi_calc < lo_calc) ? '0 : hi_calc - lo_calc + SPAN_W'(1);
  end

  assign mapped      = map_lo + prod_hi;
  assign check_sum   = {1'b0, start} + SPAN_W'(count);
  assign ptr_sum     = {1'b0, ptr} + SPAN_W'(count);
  assign wrap        = ptr_sum > {1'b0, cfg.last_lba};
  assign stream_next = wrap ? cfg.first_lba : ptr_sum[LBA_W-1:0];
  assign start_down  = start - LBA_W'(rem);

  // Kick the shared unit: multiply on accepting a seed or a hot/cold or uniform generate, remainder before alignment
  always_comb begin
    unit_ctrl.start = 1'b0;
    unit_ctrl.op    = UOP_MUL;
    if (state == ST_IDLE && accept &&
        (opcode == OPC_SEED || cfg.address_mode == MODE_HOTCOLD ||
         cfg.address_mode == MODE_UNIFORM)) begin
      unit_ctrl.start = 1'b1;
    end else if ((state == ST_STREAM || state == ST_ALIGN) && align_on) begin
      unit_ctrl.start = 1'b1;
      unit_ctrl.op    = UOP_REM;
    end
  end

  srag_unit u_unit (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (unit_ctrl),
    .mul_draw   (address_draw),
    .mul_span   (span),
    .dividend   ((state == ST_STREAM) ? stream_next : start),
    .divisor    (cfg.align_size),
    .stat       (unit_stat),
    .product_hi (prod_hi),
    .remainder  (rem)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OPC_SEED) begin
            state_next = ST_MUL;
          end else begin
            case (cfg.address_mode)
              MODE_STREAM:  state_next = ST_STREAM;
              MODE_HOTCOLD: state_next = ST_MUL;
              MODE_UNIFORM: state_next = ST_MUL;
              default:      state_next = ST_ALIGN;
            endcase
          end
        end
      end
      ST_MUL: begin
        if (unit_stat.done) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        if (op == OPC_GEN && cfg.address_mode == MODE_UNIFORM) begin
          state_next = ST_CHECK;
        end else begin
          state_next = ST_ALIGN;
        end
      end
      ST_CHECK:  state_next = ST_ALIGN;
      ST_STREAM: state_next = align_on ? ST_PREM : ST_ALIGN;
      ST_PREM: begin
        if (unit_stat.done) begin
          state_next = ST_PFIX;
        end
      end
      ST_PFIX: state_next = ST_ALIGN;
      ST_ALIGN: begin
        if (align_on) begin
          state_next = ST_SREM;
        end else begin
          state_next = (op == OPC_SEED) ? ST_IDLE : ST_DONE;
        end
      end
      ST_SREM: begin
        if (unit_stat.done) begin
          state_next = ST_SFIX;
        end
      end
      ST_SFIX: state_next = (op == OPC_SEED) ? ST_IDLE : ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Streaming pointer: control state, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      case (state)
        ST_STREAM: begin
          if (!align_on) begin
            ptr <= stream_next;
          end
        end
        ST_PFIX: begin
          // round up; wraps at the top of the address space
          if (rem != '0) begin
            ptr <= ptr_tmp + LBA_W'(cfg.align_size) - LBA_W'(rem);
          end else begin
            ptr <= ptr_tmp;
          end
        end
        ST_ALIGN: begin
          if (op == OPC_SEED && !align_on) begin
            ptr <= start;
          end
        end
        ST_SFIX: begin
          if (op == OPC_SEED) begin
            ptr <= start_down;
          end
        end
        default: ;
      endcase
    end
  end

  // Item payload
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          op     <= opcode;
          read_q <= {1'b0, type_draw} < cfg.read_threshold;
          count  <= count_calc;
          map_lo <= lo_calc;
          span   <= span_calc;
          start  <= cfg.first_lba;
        end
      end
      ST_SUM: start <= mapped[LBA_W-1:0];
      ST_CHECK: begin
        if (check_sum > {1'b0, cfg.last_lba}) begin
          start <= cfg.first_lba;
        end
      end
      ST_STREAM: begin
        start   <= wrap ? cfg.first_lba : ptr;
        ptr_tmp <= stream_next;
      end
      ST_SFIX: start <= start_down;
      default: ;
    endcase
  end

  // Output register: load from the last step, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      is_read      <= read_q;
      req_lba      <= start;
      sector_count <= count;
    end
  end

  // Checks
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector_count != '0)
    else $error("request word with zero sector count");

  a_done_when_waiting: assert property (@(posedge clk) disable iff (rst)
    unit_stat.done |-> (state == ST_MUL || state == ST_PREM || state == ST_SREM))
    else $error("shared unit finished while the sequencer was not waiting");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("input accepted without entering the work sequence");

  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    unit_ctrl.start |-> !unit_stat.busy)
    else $error("shared unit started while still busy");

endmodule

// ===== sv/srag_cfg.sv =====
// Configuration register file of the storage request address generator.
`timescale 1ns / 1ps
module srag_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [srag_pkg::IDX_W-1:0]  cfg_index,
  input  logic [srag_pkg::LBA_W-1:0]  cfg_data,
  output srag_pkg::cfg_t              cfg
);
  import srag_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.address_mode   <= MODE_STREAM;
      cfg.read_threshold <= THR_W'(32768);
      cfg.hot_threshold  <= '0;
      cfg.first_lba      <= '0;
      cfg.last_lba       <= '0;
      cfg.hot_end_lba    <= '0;
      cfg.fixed_size     <= CNT_W'(8);
      cfg.align_size     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADDRESS_MODE:   cfg.address_mode   <= cfg_data[MODE_W-1:0];
        REG_READ_THRESHOLD: cfg.read_threshold <= cfg_data[THR_W-1:0];
        REG_HOT_THRESHOLD:  cfg.hot_threshold  <= cfg_data[THR_W-1:0];
        REG_FIRST_LBA:      cfg.first_lba      <= cfg_data;
        REG_LAST_LBA:       cfg.last_lba       <= cfg_data;
        REG_HOT_END_LBA:    cfg.hot_end_lba    <= cfg_data;
        REG_FIXED_SIZE:     cfg.fixed_size     <= cfg_data[CNT_W-1:0];
        REG_ALIGN_SIZE:     cfg.align_size     <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/srag_unit.sv =====
// Shared iterative unit: shift-add multiply or restoring remainder, one bit a cycle.
`timescale 1ns / 1ps
module srag_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  srag_pkg::unit_ctrl_t        ctrl,
  input  logic [srag_pkg::DRAW_W-1:0] mul_draw,
  input  logic [srag_pkg::SPAN_W-1:0] mul_span,
  input  logic [srag_pkg::LBA_W-1:0]  dividend,
  input  logic [srag_pkg::CNT_W-1:0]  divisor,
  output srag_pkg::unit_stat_t        stat,
  output logic [srag_pkg::SPAN_W-1:0] product_hi,
  output logic [srag_pkg::CNT_W-1:0]  remainder
);
  import srag_pkg::*;

  unit_op_t            op;
  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   cnt;
  logic [SPAN_W-1:0]   hi;
  logic [DRAW_W-1:0]   lo;
  logic [LBA_W-1:0]    dvd;
  logic [CNT_W-1:0]    rem;
  logic [CNT_W:0]      trial;
  logic [ADD_W-1:0]    add_a;
  logic [ADD_W-1:0]    add_b;
  logic                add_cin;
  logic [ADD_W-1:0]    add_sum;

  assign trial = {rem, dvd[LBA_W-1]};

  // One adder serves both operations
  always_comb begin
    if (op == UOP_MUL) begin
      add_a   = {1'b0, hi};
      add_b   = lo[0] ? {1'b0, mul_span} : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = ADD_W'(trial);
      add_b   = ~ADD_W'(divisor);
      add_cin = 1'b1;
    end
    add_sum = add_a + add_b + ADD_W'(add_cin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op   <= UOP_MUL;
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        op   <= ctrl.op;
        busy <= 1'b1;
        cnt  <= (ctrl.op == UOP_MUL) ? STEP_W'(MUL_STEPS - 1) : STEP_W'(REM_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - STEP_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      hi  <= '0;
      lo  <= mul_draw;
      rem <= '0;
      dvd <= dividend;
    end else if (busy) begin
      if (op == UOP_MUL) begin
        hi <= add_sum[ADD_W-1:1];
        lo <= {add_sum[0], lo[DRAW_W-1:1]};
      end else begin
        rem <= add_sum[ADD_W-1] ? trial[CNT_W-1:0] : add_sum[CNT_W-1:0];
        dvd <= {dvd[LBA_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy  = busy;
  assign stat.done  = done;
  assign product_hi = hi;
  assign remainder  = rem;

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the storage request address generator.
`timescale 1ns / 1ps
module tb;
  import srag_pkg::*;

  // Opcodes of an input word
  localparam logic OP_SEED     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;
  // The fourth address mode has no name in the package: start at first_lba
  localparam logic [MODE_W-1:0] MODE_FIXED_FIRST = 2'd3;

  localparam logic [LBA_W-1:0] LBA_MAX = {LBA_W{1'b1}};

  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 200;   // covers a seed still in work
  localparam int STUCK_LIMIT   = 4000;  // cycles with no word moving on any channel
  localparam int PRINT_LIMIT   = 40;

  typedef struct packed {
    logic             is_read;
    logic [LBA_W-1:0] req_lba;
    logic [CNT_W-1:0] sector_count;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = 1'b0;
  logic [Q16_W-1:0]         type_draw = '0;
  logic [Q16_W-1:0]         hot_draw = '0;
  logic [DRAW_W-1:0]        address_draw = '0;
  logic signed [15:0]       size_draw = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     is_read;
  logic [LBA_W-1:0]         req_lba;
  logic [CNT_W-1:0]         sector_count;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_W-1:0]         cfg_index = '0;
  logic [LBA_W-1:0]         cfg_data = '0;

  // Predictor state: a private copy of the registers and the streaming pointer
  cfg_t             cfg_model;
  logic [LBA_W-1:0] stream_ptr;
  request_t         pending_requests[$];

  int   fail_count = 0;
  int   stuck_cycles = 0;
  logic steady = 1'b0;          // set for a stretch with no idling on either side
  int   hold_requests = 0;      // bumped by a test to ask for a long hold-off
  int   hold_served = 0;
  int   hold_left = 0;

  storage_request_address_generator u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .type_draw    (type_draw),
    .hot_draw     (hot_draw),
    .address_draw (address_draw),
    .size_draw    (size_draw),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_read      (is_read),
    .req_lba      (req_lba),
    .sector_count (sector_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Request predictor
  // ---------------------------------------------------------------------------

  // Map a 32-bit draw onto [lo, hi] as lo + ((draw * span) >> 32), exact.
  // An empty range (hi below lo) gives lo.
  function automatic logic [63:0] map_onto(input logic [63:0] lo, input logic [63:0] hi,
                                           input logic [DRAW_W-1:0] draw);
    logic [95:0] prod;
    if (hi < lo) return lo;
    prod = {64'd0, draw} * {32'd0, hi - lo + 64'd1};
    return lo + prod[95:32];
  endfunction

  function automatic logic [63:0] align_down(input logic [63:0] a, input logic [63:0] align);
    if (align == 0) return a;
    return a - a % align;
  endfunction

  // Work out the request an accepted word causes; returns 0 for a seed word.
  // Advances the streaming pointer as the block does.
  function automatic bit next_request(input logic op, input logic [Q16_W-1:0] td,
                                      input logic [Q16_W-1:0] hd,
                                      input logic [DRAW_W-1:0] ad,
                                      input logic signed [15:0] sd,
                                      output request_t req);
    logic [63:0] first, last, align, cnt, start, ptr, rem;
    first = {16'd0, cfg_model.first_lba};
    last  = {16'd0, cfg_model.last_lba};
    align = {48'd0, cfg_model.align_size};
    req   = '0;

    // A seed loads the pointer whatever the address mode
    if (op == OP_SEED) begin
      ptr = align_down(map_onto(first, last, ad), align);
      stream_ptr = ptr[LBA_W-1:0];
      return 1'b0;
    end

    req.is_read = {1'b0, td} < cfg_model.read_threshold;

    // Fixed size wins; otherwise the size draw, with zero or negative raised to 1
    if (cfg_model.fixed_size != 0)
      cnt = {48'd0, cfg_model.fixed_size};
    else if (sd <= 0)
      cnt = 64'd1;
    else
      cnt = {48'd0, sd};

    case (cfg_model.address_mode)
      MODE_STREAM: begin
        start = {16'd0, stream_ptr};
        if (start + cnt > last) start = first;
        ptr = {16'd0, stream_ptr} + cnt;
        if (ptr > last) ptr = first;
        // Round the pointer up; it may wrap past the top of the address space
        if (align != 0) begin
          rem = ptr % align;
          if (rem != 0) ptr = ptr + align - rem;
        end
        stream_ptr = ptr[LBA_W-1:0];
      end
      MODE_HOTCOLD: begin
        // Upper region starts one past hot_end_lba; at the top that is 2^48
        if ({1'b0, hd} < cfg_model.hot_threshold)
          start = map_onto({16'd0, cfg_model.hot_end_lba} + 64'd1, last, ad);
        else
          start = map_onto(first, {16'd0, cfg_model.hot_end_lba}, ad);
      end
      MODE_UNIFORM: begin
        start = map_onto(first, last, ad);
        if (start + cnt > last) start = first;
      end
      default: start = first;
    endcase

    start = align_down({16'd0, start[LBA_W-1:0]}, align);
    req.req_lba      = start[LBA_W-1:0];
    req.sector_count = cnt[CNT_W-1:0];
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    // Keep the log short on a broken build; every failure still counts
    if (fail_count < PRINT_LIMIT)
      $display("%0t MISMATCH %s: got %0h, expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compare each accepted request word with the oldest expectation
  always @(posedge clk) begin : check_requests
    request_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_requests.size() == 0) begin
        flag_mismatch("request word with nothing expected", req_lba, 0);
      end else begin
        want = pending_requests.pop_front();
        if (is_read !== want.is_read)
          flag_mismatch("is_read", is_read, want.is_read);
        if (req_lba !== want.req_lba)
          flag_mismatch("req_lba", req_lba, want.req_lba);
        if (sector_count !== want.sector_count)
          flag_mismatch("sector_count", sector_count, want.sector_count);
      end
    end
  end

  // Drop the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, a long hold-off on request, none while steady
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
      hold_served <= hold_served + 1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 25);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one input word; entered and left at a falling edge. Valid stays high
  // on return so back-to-back words never lower and raise it in one step;
  // whoever stops sending lowers it.
  task automatic send_word(input logic op, input logic [Q16_W-1:0] td,
                           input logic [Q16_W-1:0] hd, input logic [DRAW_W-1:0] ad,
                           input logic signed [15:0] sd);
    request_t req;
    if (!steady && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    opcode       <= op;
    type_draw    <= td;
    hot_draw     <= hd;
    address_draw <= ad;
    size_draw    <= sd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (next_request(op, td, hd, ad, sd, req))
      pending_requests.push_back(req);
    @(negedge clk);
  endtask

  // Hold the sender until every expected request has come out; it always waits
  // for a falling edge with valid low, so valid is never lowered and raised in one step
  task automatic await_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_requests.size() != 0) @(negedge clk);
  endtask

  // Write one register; only called while the block is idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [LBA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ADDRESS_MODE:   cfg_model.address_mode   = data[MODE_W-1:0];
      REG_READ_THRESHOLD: cfg_model.read_threshold = data[THR_W-1:0];
      REG_HOT_THRESHOLD:  cfg_model.hot_threshold  = data[THR_W-1:0];
      REG_FIRST_LBA:      cfg_model.first_lba      = data;
      REG_LAST_LBA:       cfg_model.last_lba       = data;
      REG_HOT_END_LBA:    cfg_model.hot_end_lba    = data;
      REG_FIXED_SIZE:     cfg_model.fixed_size     = data[CNT_W-1:0];
      default:            cfg_model.align_size     = data[CNT_W-1:0];
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain, let a seed with no result finish, then rewrite every register
  task automatic load_config(input logic [MODE_W-1:0] mode, input logic [THR_W-1:0] rd_thr,
                             input logic [THR_W-1:0] hot_thr, input logic [LBA_W-1:0] first,
                             input logic [LBA_W-1:0] last, input logic [LBA_W-1:0] hot_end,
                             input logic [CNT_W-1:0] fixed, input logic [CNT_W-1:0] align);
    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(REG_ADDRESS_MODE, {{(LBA_W-MODE_W){1'b0}}, mode});
    write_reg(REG_READ_THRESHOLD, {{(LBA_W-THR_W){1'b0}}, rd_thr});
    write_reg(REG_HOT_THRESHOLD, {{(LBA_W-THR_W){1'b0}}, hot_thr});
    write_reg(REG_FIRST_LBA, first);
    write_reg(REG_LAST_LBA, last);
    write_reg(REG_HOT_END_LBA, hot_end);
    write_reg(REG_FIXED_SIZE, {{(LBA_W-CNT_W){1'b0}}, fixed});
    write_reg(REG_ALIGN_SIZE, {{(LBA_W-CNT_W){1'b0}}, align});
  endtask

  function automatic logic [LBA_W-1:0] rand_lba();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[LBA_W-1:0];
  endfunction

  function automatic logic [THR_W-1:0] rand_threshold();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 17'd65536;
      default: return $urandom_range(65536);
    endcase
  endfunction

  // Random register set: small working sets at times so the wrap and replacement
  // paths fire, with wide, top-reaching and inverted ranges mixed in
  task automatic load_random_config();
    logic [MODE_W-1:0] mode;
    logic [63:0]       first, last, hot_end;
    logic [CNT_W-1:0]  fixed, align;
    if ($urandom_range(9) == 0) mode = MODE_FIXED_FIRST;
    else mode = $urandom_range(2);
    case ($urandom_range(4))
      0: begin first = $urandom_range(200); last = first + $urandom_range(3000); end
      1: begin first = $urandom; last = first + $urandom; end
      2: begin
        first = {16'd0, rand_lba()} >> 2;
        last  = first + ({16'd0, rand_lba()} >> 2);
      end
      3: begin first = {16'd0, rand_lba()}; last = {16'd0, LBA_MAX}; end
      default: begin first = {16'd0, rand_lba()}; last = {16'd0, rand_lba()}; end
    endcase
    case ($urandom_range(5))
      0: hot_end = {16'd0, LBA_MAX};
      1: hot_end = (first == 0) ? 64'd0 : first - 64'd1;
      default: hot_end = (last >= first) ? first + ({16'd0, rand_lba()} % (last - first + 1))
                                         : {16'd0, rand_lba()};
    endcase
    case ($urandom_range(7))
      4:       fixed = 16'hFFFF;
      5:       fixed = 16'd1;
      6:       fixed = $urandom_range(1, 64);
      7:       fixed = $urandom_range(1, 65535);
      default: fixed = '0;
    endcase
    case ($urandom_range(7))
      4:       align = $urandom_range(1, 16);
      5:       align = 16'hFFFF;
      6:       align = 16'd4096;
      7:       align = $urandom_range(1, 65535);
      default: align = '0;
    endcase
    load_config(mode, rand_threshold(), rand_threshold(), first[LBA_W-1:0], last[LBA_W-1:0],
                hot_end[LBA_W-1:0], fixed, align);
  endtask

  // One word with random content; address and size draws lean toward edges
  task automatic send_random_word(input logic op);
    logic [DRAW_W-1:0]  ad;
    logic signed [15:0] sd;
    case ($urandom_range(9))
      0:       ad = '0;
      1:       ad = '1;
      default: ad = $urandom;
    endcase
    case ($urandom_range(3))
      0:       sd = $urandom_range(65535);
      1:       sd = $urandom_range(1, 64);
      2:       sd = -$urandom_range(3);
      default: sd = $urandom_range(1, 32767);
    endcase
    send_word(op, $urandom_range(65535), $urandom_range(65535), ad, sd);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: streaming over a single-LBA set (first and last both zero), pointer zero until seeded
  task automatic test_reset_defaults();
    send_word(OP_GENERATE, 16'h0000, 16'h0000, 32'h0000_0000, 16'sd0);
    send_word(OP_GENERATE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, -16'sd32768);
    send_word(OP_SEED,     16'h1234, 16'h4321, 32'hFFFF_FFFF, 16'sd5);
    send_word(OP_GENERATE, 16'h8000, 16'h7FFF, 32'h8000_0000, 16'sd32767);
  endtask

  // Streaming: size draw edges, wrap to first_lba, alignment, pointer wrap at 2^48
  task automatic test_streaming();
    load_config(MODE_STREAM, 17'd65536, '0, 48'd100, 48'd1000, 48'd500, 16'd0, 16'd0);
    send_word(OP_GENERATE, 16'hFFFF, 16'h0000, 32'h0000_0000, 16'sd1);
    send_word(OP_SEED,     16'h0000, 16'h0000, 32'hFFFF_FFFF, 16'sd0);
    send_word(OP_GENERATE, 16'hFFFF, 16'h0000, 32'h0000_0000, 16'sd32767);
    send_word(OP_GENERATE, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF, 16'sd0);
    send_word(OP_GENERATE, 16'h5555, 16'hAAAA, 32'h5555_5555, -16'sd32768);

    load_config(MODE_STREAM, '0, '0, 48'd100, 48'd1000, 48'd500, 16'd0, 16'd7);
    send_word(OP_SEED,     16'h0000, 16'h0000, 32'h8000_0000, 16'sd0);
    send_word(OP_GENERATE, 16'h0000, 16'h0000, 32'h0000_0000, 16'sd5);
    send_word(OP_GENERATE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'sd30000);

    // Pointer near the top: rounding up to an odd-free alignment wraps it
    load_config(MODE_STREAM, 17'd32768, '0, '0, LBA_MAX, '0, 16'd1, 16'd65534);
    send_word(OP_SEED,     16'h0000, 16'h0000, 32'hFFFF_FFFF, 16'sd0);
    send_word(OP_GENERATE, 16'h7FFF, 16'h0000, 32'h1234_5678, 16'sd9);
    send_word(OP_GENERATE, 16'h8000, 16'h0000, 32'h8765_4321, 16'sd9);
    send_word(OP_GENERATE, 16'h0001, 16'h0000, 32'h0F0F_0F0F, 16'sd9);
  endtask

  // Hot/cold regions, upper region past the top, cold region empty
  task automatic test_hot_cold();
    load_config(MODE_HOTCOLD, 17'd32768, 17'd32768, 48'd1000, 48'd90000, 48'd5000,
                16'd16, 16'd0);
    send_word(OP_GENERATE, 16'h0000, 16'h0000, 32'h0000_0000, 16'sd0);
    send_word(OP_GENERATE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'sd0);

    load_config(MODE_HOTCOLD, 17'd32768, 17'd65536, 48'd1000, 48'd90000, LBA_MAX,
                16'd16, 16'd0);
    send_word(OP_GENERATE, 16'h1111, 16'hFFFF, 32'h0000_1234, 16'sd0);

    load_config(MODE_HOTCOLD, 17'd32768, '0, 48'd1000, 48'd90000, 48'd500, 16'd16, 16'd0);
    send_word(OP_GENERATE, 16'h2222, 16'h0000, 32'hFFFF_FFFF, 16'sd0);
  endtask

  // Uniform: draw extremes, replacement near the top, inverted range, seed here too
  task automatic test_uniform();
    load_config(MODE_UNIFORM, 17'd32768, '0, 48'd4096, 48'h0100_0000_0000, '0,
                16'hFFFF, 16'd4096);
    send_word(OP_GENERATE, 16'h0000, 16'h0000, 32'h0000_0000, 16'sd0);
    send_word(OP_GENERATE, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 16'sd0);
    send_word(OP_SEED,     16'h0000, 16'h0000, 32'h4000_0000, 16'sd0);

    load_config(MODE_UNIFORM, 17'd32768, '0, 48'd5000, 48'd10, '0, 16'd1, 16'd0);
    send_word(OP_GENERATE, 16'h4000, 16'h0000, 32'h9999_9999, 16'sd0);
  endtask

  // Mode three: always first_lba, then aligned down; a seed still lands
  task automatic test_mode_three();
    load_config(MODE_FIXED_FIRST, 17'd32768, '0, 48'd123456, 48'd200000, '0,
                16'd3, 16'd1000);
    send_word(OP_GENERATE, 16'h0000, 16'h0000, 32'hABCD_EF01, 16'sd0);
    send_word(OP_SEED,     16'h0000, 16'h0000, 32'hFFFF_FFFF, 16'sd0);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // then the sender waits for every result
  task automatic test_backpressure();
    int k;
    load_random_config();
    hold_requests++;
    send_random_word(OP_SEED);
    for (k = 0; k < 24; k++) send_random_word(OP_GENERATE);
    await_results();
  endtask

  // Phases of random registers, each a seed followed mostly by generates,
  // with occasional stray seeds and pauses; one phase runs with no idling
  task automatic test_random_traffic();
    int phase, k;
    for (phase = 0; phase < 30; phase++) begin
      load_random_config();
      steady = (phase == 7);
      if (phase == 15) hold_requests++;
      send_random_word(OP_SEED);
      for (k = 0; k < 60; k++) begin
        if ($urandom_range(39) == 0) await_results();
        send_random_word(($urandom_range(9) == 0) ? OP_SEED : OP_GENERATE);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    cfg_model.address_mode   = MODE_STREAM;
    cfg_model.read_threshold = 17'd32768;
    cfg_model.hot_threshold  = '0;
    cfg_model.first_lba      = '0;
    cfg_model.last_lba       = '0;
    cfg_model.hot_end_lba    = '0;
    cfg_model.fixed_size     = 16'd8;
    cfg_model.align_size     = '0;
    stream_ptr               = '0;

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_streaming();
    test_hot_cold();
    test_uniform();
    test_mode_three();
    test_backpressure();
    test_random_traffic();

    // Drain, then give a trailing seed time to settle
    await_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_requests.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
